### hw/rtl/ocfcs_pkg.sv
// Shared types and constants for the oldest-cell-first crossbar scheduler.
package ocfcs_pkg;

    localparam logic [1:0] ACT_LOAD_QUEUE = 2'd0;
    localparam logic [1:0] ACT_LOAD_OCC   = 2'd1;
    localparam logic [1:0] ACT_SCHEDULE   = 2'd2;

    localparam logic [1:0] CFG_LIMIT_ENABLE = 2'd0;
    localparam logic [1:0] CFG_MAX_CELLS    = 2'd1;
    localparam logic [1:0] CFG_LINES        = 2'd2;
    localparam logic [1:0] CFG_LFSR_SEED    = 2'd3;

    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [15:0] LFSR_ONE  = 16'h0001;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ,
        S_GLOAD,
        S_GSLOT,
        S_GDIV,
        S_GEMIT
    } state_t;

endpackage

### hw/rtl/oldest_cell_first_crossbar_scheduler.sv
// Oldest-cell-first crossbar scheduler: request scan and random grant sequencer.
// A schedule scans the head times (64 at defaults) through one RAM read port, then
// visits each output and each of its lines; a line with requesters gets a grant drawn
// by a shared bit-serial modulo of the LFSR, and output stalls hold the emit. One item
// at a time; input stalls for the whole run. Async active-low reset clears valid bits,
// occupancies, requests, limit enable and cell cap; lines = 1, LFSR = 1.
module oldest_cell_first_crossbar_scheduler
    import ocfcs_pkg::*;
#(
    parameter int NUM_PORTS = 8,
    parameter int MAX_LINES = 2,
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [2:0]  in_port,
    input  logic [2:0]  out_port,
    input  logic        queue_nonempty,
    input  logic [31:0] head_time,
    input  logic [15:0] out_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  fabric_line,
    output logic        grant_valid,
    output logic [2:0]  grant_input,
    output logic        last
);

    localparam int NQ = NUM_PORTS * NUM_PORTS;
    localparam int AW = $clog2(NQ);
    localparam int IB = $clog2(NUM_PORTS);
    localparam int CW = $clog2(NUM_PORTS + 1);
    localparam int SW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LW = $clog2(MAX_LINES + 1);

    state_t state_reg, state_next;

    logic                 limit_reg;
    logic [15:0]          max_cells_reg;
    logic [1:0]           lines_reg;
    logic [15:0]          lfsr_reg, lfsr_next;

    logic [NQ-1:0]        qvalid_reg;
    logic [15:0]          occ_reg [NUM_PORTS];
    logic [NUM_PORTS-1:0] req_v_reg;
    logic [IB-1:0]        req_out_reg [NUM_PORTS];

    logic [IB-1:0]        iss_i_reg, iss_o_reg;
    logic                 iss_done_reg;
    logic                 rd_v_reg;
    logic [IB-1:0]        rd_i_reg, rd_o_reg;
    logic                 found_reg;
    logic [TIME_BITS-1:0] best_reg;
    logic [IB-1:0]        best_out_reg;

    logic [IB-1:0]        o_reg;
    logic [SW-1:0]        slot_reg;
    logic [NUM_PORTS-1:0] mask_reg;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        rem_reg;
    logic [3:0]           bitc_reg;

    logic                 out_valid_reg;
    logic [3:0]           out_line_reg;
    logic                 out_grant_reg;
    logic [2:0]           out_input_reg;
    logic                 out_last_reg;

    logic                 in_xfer;
    logic                 room;
    logic [LW-1:0]        eff_lines;
    logic                 slot_end;
    logic                 o_end;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [TIME_BITS-1:0] rdata;
    logic                 wr_ok;
    logic                 elig;
    logic                 take;
    logic                 found_new;
    logic [NUM_PORTS-1:0] req_mask;
    logic [CW-1:0]        cnt_now;
    logic [CW:0]          rem_sh;
    logic [CW-1:0]        rem_new;
    logic [IB-1:0]        sel_idx;
    logic [CW-1:0]        run_cnt;
    logic                 emit_none;
    logic                 emit_grant;
    logic                 advance;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign room     = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (lines_reg == 2'd0)
        begin
            eff_lines = LW'(1);
        end
        else if (int'(lines_reg) > MAX_LINES)
        begin
            eff_lines = LW'(MAX_LINES);
        end
        else
        begin
            eff_lines = LW'(lines_reg);
        end
    end

    assign slot_end = (LW'(slot_reg) + LW'(1)) == eff_lines;
    assign o_end    = (int'(o_reg) == NUM_PORTS - 1);

    assign wr_ok = in_xfer && (action == ACT_LOAD_QUEUE)
                   && (int'(in_port) < NUM_PORTS) && (int'(out_port) < NUM_PORTS);
    assign waddr = AW'(int'(in_port) * NUM_PORTS + int'(out_port));
    assign raddr = AW'(int'(iss_i_reg) * NUM_PORTS + int'(iss_o_reg));

    ocfcs_ram #(
        .WIDTH(TIME_BITS),
        .DEPTH(NQ)
    ) u_head_ram (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (waddr),
        .wdata (TIME_BITS'(head_time)),
        .raddr (raddr),
        .rdata (rdata)
    );

    // request scan compare
    assign elig = qvalid_reg[AW'(int'(rd_i_reg) * NUM_PORTS + int'(rd_o_reg))]
                  && (!limit_reg || (occ_reg[rd_o_reg] < max_cells_reg));
    assign take = rd_v_reg && elig && (!found_reg || (rdata < best_reg));
    assign found_new = found_reg || take;

    // grant selection
    always_comb
    begin
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            req_mask[i] = req_v_reg[i] && (req_out_reg[i] == o_reg);
        end
    end

    assign cnt_now = CW'($countones(mask_reg));
    assign rem_sh  = {rem_reg, lfsr_reg[4'd15 - bitc_reg]};
    assign rem_new = (rem_sh >= {1'b0, cnt_reg}) ? CW'(rem_sh - {1'b0, cnt_reg})
                                                 : CW'(rem_sh);

    always_comb
    begin
        sel_idx = '0;
        run_cnt = '0;
        for (int k = 0; k < NUM_PORTS; k++)
        begin
            if (mask_reg[k])
            begin
                if (run_cnt == rem_reg)
                begin
                    sel_idx = IB'(k);
                end
                run_cnt = run_cnt + CW'(1);
            end
        end
    end

    assign emit_none  = (state_reg == S_GSLOT) && (cnt_now == '0) && room;
    assign emit_grant = (state_reg == S_GEMIT) && room;
    assign advance    = emit_none || emit_grant;

    always_comb
    begin
        lfsr_next = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? LFSR_MASK : 16'h0000);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (action == ACT_SCHEDULE))
                begin
                    state_next = S_REQ;
                end
            end
            S_REQ:
            begin
                if (rd_v_reg && iss_done_reg && (int'(rd_i_reg) == NUM_PORTS - 1)
                    && (int'(rd_o_reg) == NUM_PORTS - 1))
                begin
                    state_next = S_GLOAD;
                end
            end
            S_GLOAD:
            begin
                state_next = S_GSLOT;
            end
            S_GSLOT:
            begin
                if (cnt_now != '0)
                begin
                    state_next = S_GDIV;
                end
            end
            S_GDIV:
            begin
                if (bitc_reg == 4'd15)
                begin
                    state_next = S_GEMIT;
                end
            end
            S_GEMIT:
            begin
                state_next = S_GEMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (advance)
        begin
            if (slot_end)
            begin
                state_next = o_end ? S_IDLE : S_GLOAD;
            end
            else
            begin
                state_next = S_GSLOT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= 1'b0;
            max_cells_reg <= '0;
            lines_reg     <= 2'd1;
            lfsr_reg      <= LFSR_ONE;
            qvalid_reg    <= '0;
            req_v_reg     <= '0;
            iss_done_reg  <= 1'b0;
            rd_v_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            iss_i_reg     <= '0;
            iss_o_reg     <= '0;
            o_reg         <= '0;
            slot_reg      <= '0;
            bitc_reg      <= '0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                occ_reg[i]     <= '0;
                req_out_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LIMIT_ENABLE: limit_reg     <= cfg_data[0];
                    CFG_MAX_CELLS:    max_cells_reg <= cfg_data;
                    CFG_LINES:        lines_reg     <= cfg_data[1:0];
                    CFG_LFSR_SEED:    lfsr_reg      <= (cfg_data != '0) ? cfg_data : LFSR_ONE;
                    default:          ;
                endcase
            end

            if (wr_ok)
            begin
                qvalid_reg[waddr] <= queue_nonempty;
            end
            if (in_xfer && (action == ACT_LOAD_OCC) && (int'(out_port) < NUM_PORTS))
            begin
                occ_reg[IB'(out_port)] <= out_count;
            end

            if (in_xfer && (action == ACT_SCHEDULE))
            begin
                iss_i_reg    <= '0;
                iss_o_reg    <= '0;
                iss_done_reg <= 1'b0;
                found_reg    <= 1'b0;
                rd_v_reg     <= 1'b0;
            end

            if (state_reg == S_REQ)
            begin
                rd_v_reg <= !iss_done_reg;
                rd_i_reg <= iss_i_reg;
                rd_o_reg <= iss_o_reg;
                if (!iss_done_reg)
                begin
                    if (int'(iss_o_reg) == NUM_PORTS - 1)
                    begin
                        iss_o_reg <= '0;
                        if (int'(iss_i_reg) == NUM_PORTS - 1)
                        begin
                            iss_done_reg <= 1'b1;
                        end
                        else
                        begin
                            iss_i_reg <= iss_i_reg + IB'(1);
                        end
                    end
                    else
                    begin
                        iss_o_reg <= iss_o_reg + IB'(1);
                    end
                end
                if (rd_v_reg)
                begin
                    if (take)
                    begin
                        best_reg     <= rdata;
                        best_out_reg <= rd_o_reg;
                    end
                    if (int'(rd_o_reg) == NUM_PORTS - 1)
                    begin
                        found_reg             <= 1'b0;
                        req_v_reg[rd_i_reg]   <= found_new;
                        req_out_reg[rd_i_reg] <= take ? rd_o_reg
                                               : (found_reg ? best_out_reg : '0);
                    end
                    else
                    begin
                        found_reg <= found_new;
                    end
                end
                if (state_next == S_GLOAD)
                begin
                    o_reg    <= '0;
                    slot_reg <= '0;
                end
            end

            if (state_reg == S_GLOAD)
            begin
                mask_reg <= req_mask;
            end

            if ((state_reg == S_GSLOT) && (cnt_now != '0))
            begin
                lfsr_reg <= lfsr_next;
                cnt_reg  <= cnt_now;
                rem_reg  <= '0;
                bitc_reg <= '0;
            end

            if (state_reg == S_GDIV)
            begin
                rem_reg  <= rem_new;
                bitc_reg <= bitc_reg + 4'd1;
            end

            if (emit_grant)
            begin
                mask_reg[sel_idx] <= 1'b0;
            end

            if (advance)
            begin
                if (slot_end)
                begin
                    slot_reg <= '0;
                    o_reg    <= o_reg + IB'(1);
                end
                else
                begin
                    slot_reg <= slot_reg + SW'(1);
                end
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_line_reg  <= 4'(int'(o_reg) * int'(eff_lines) + int'(slot_reg));
            out_grant_reg <= emit_grant;
            out_input_reg <= emit_grant ? 3'(sel_idx) : 3'd0;
            out_last_reg  <= o_end && slot_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign fabric_line = out_line_reg;
    assign grant_valid = out_grant_reg;
    assign grant_input = out_input_reg;
    assign last        = out_last_reg;

`ifndef SYNTHESIS
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("lfsr reached zero");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GDIV) |-> (cnt_reg != '0) && (rem_reg < cnt_reg))
        else $error("modulo unit out of range");

    a_emit_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GEMIT) |-> (mask_reg != '0))
        else $error("grant with no requester left");

    a_rd_in_req: assert property (@(posedge clk) disable iff (!rst_n)
        rd_v_reg |-> (state_reg == S_REQ))
        else $error("scan read outside request phase");
`endif

endmodule

### hw/rtl/ocfcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ocfcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### tb/sv/ocfcs_grant_monitor.sv
// Transfer monitor: predicts and checks the grant results of the crossbar scheduler.
`timescale 1ns / 1ps
module ocfcs_grant_monitor
    import ocfcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  action,
    input  logic [2:0]  in_port,
    input  logic [2:0]  out_port,
    input  logic        queue_nonempty,
    input  logic [31:0] head_time,
    input  logic [15:0] out_count,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  fabric_line,
    input  logic        grant_valid,
    input  logic [2:0]  grant_input,
    input  logic        last,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [3:0] line;
        logic       granted;
        logic [2:0] winner;
        logic       tail;
    } grant_t;

    grant_t      grants_due[$];
    bit          voq_busy[64];
    logic [31:0] voq_time[64];
    logic [15:0] occupancy[8];
    logic [15:0] lfsr;
    logic        limit_on;
    logic [15:0] cell_cap;
    logic [1:0]  line_cfg;

    function automatic logic [15:0] lfsr_step(logic [15:0] v);
        return v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
    endfunction

    task automatic predict_schedule();
        bit          req_ok[8];
        int          req_out[8];
        int          cand[8];
        int          cnt;
        int          pick;
        int          nl;
        bit          found;
        logic [31:0] best;
        grant_t      g;
        for (int i = 0; i < 8; i++)
        begin
            found = 0;
            best = '0;
            req_out[i] = 0;
            for (int o = 0; o < 8; o++)
            begin
                if (voq_busy[i*8+o] && (!limit_on || occupancy[o] < cell_cap) &&
                    (!found || voq_time[i*8+o] < best))
                begin
                    found = 1;
                    best = voq_time[i*8+o];
                    req_out[i] = o;
                end
            end
            req_ok[i] = found;
        end
        nl = (line_cfg == 0) ? 1 : (line_cfg > 2 ? 2 : int'(line_cfg));
        for (int o = 0; o < 8; o++)
        begin
            cnt = 0;
            for (int i = 0; i < 8; i++)
                if (req_ok[i] && req_out[i] == o)
                begin
                    cand[cnt] = i;
                    cnt++;
                end
            for (int s = 0; s < nl; s++)
            begin
                g.line = 4'(o * nl + s);
                g.tail = (o == 7) && (s == nl - 1);
                if (cnt > 0)
                begin
                    lfsr = lfsr_step(lfsr);
                    pick = int'(lfsr) % cnt;
                    g.granted = 1;
                    g.winner = 3'(cand[pick]);
                    for (int k = pick; k + 1 < cnt; k++)
                        cand[k] = cand[k+1];
                    cnt--;
                end
                else
                begin
                    g.granted = 0;
                    g.winner = '0;
                end
                grants_due.push_back(g);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        grant_t seen;
        if (!rst_n)
        begin
            for (int q = 0; q < 64; q++)
                voq_busy[q] = 0;
            for (int o = 0; o < 8; o++)
                occupancy[o] = '0;
            lfsr = LFSR_ONE;
            limit_on = 0;
            cell_cap = '0;
            line_cfg = 2'd1;
            grants_due.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LIMIT_ENABLE: limit_on = cfg_data[0];
                    CFG_MAX_CELLS:    cell_cap = cfg_data;
                    CFG_LINES:        line_cfg = cfg_data[1:0];
                    CFG_LFSR_SEED:    lfsr = (cfg_data == 0) ? LFSR_ONE : cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                case (action)
                    ACT_LOAD_QUEUE:
                    begin
                        voq_busy[in_port*8+out_port] = queue_nonempty;
                        voq_time[in_port*8+out_port] = head_time;
                    end
                    ACT_LOAD_OCC: occupancy[out_port] = out_count;
                    ACT_SCHEDULE: predict_schedule();
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                seen = '{fabric_line, grant_valid, grant_input, last};
                if (grants_due.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %p", $time, seen);
                    errors++;
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (seen !== want)
                    begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, seen);
                        errors++;
                    end
                end
            end
        end
        pending = grants_due.size();
    end

endmodule

### tb/sv/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the crossbar scheduler.
`timescale 1ns / 1ps
module testbench;
    import ocfcs_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  action = '0;
    logic [2:0]  in_port = '0;
    logic [2:0]  out_port = '0;
    logic        queue_nonempty = 0;
    logic [31:0] head_time = '0;
    logic [15:0] out_count = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [3:0]  fabric_line;
    logic        grant_valid;
    logic [2:0]  grant_input;
    logic        last;
    int          errors;
    int          pending;
    logic        in_fire = 0;
    bit          steady = 0;
    bit          hold_go = 0;
    int          hold_left = 0;

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    oldest_cell_first_crossbar_scheduler i_dut (.*);

    ocfcs_grant_monitor i_monitor (.*);

    always @(posedge clk)
        in_fire <= in_valid && !in_stall;

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1;
            hold_left--;
        end
        else if (hold_go)
        begin
            out_stall <= 1;
            hold_left = 600;
            hold_go = 0;
        end
        else
            out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 30);
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send(logic [1:0] act, logic [2:0] ip, logic [2:0] op, logic ne,
                        logic [31:0] ht, logic [15:0] cnt);
        while (!steady && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        action <= act;
        in_port <= ip;
        out_port <= op;
        queue_nonempty <= ne;
        head_time <= ht;
        out_count <= cnt;
        do
            @(negedge clk);
        while (!in_fire);
    endtask

    task automatic settle();
        in_valid <= 0;
        wait (pending == 0);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic random_items(int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send(ACT_LOAD_QUEUE, 3'($urandom), 3'($urandom), $urandom_range(0, 3) != 0,
                     $urandom_range(0, 1) ? 32'($urandom_range(0, 15)) : $urandom, '0);
            else if (r < 78)
                send(ACT_LOAD_OCC, 3'($urandom), 3'($urandom), 1'($urandom), $urandom,
                     $urandom_range(0, 1) ? 16'($urandom_range(0, 8)) : 16'($urandom));
            else if (r < 95)
                send(ACT_SCHEDULE, 3'($urandom), 3'($urandom), 1'($urandom), $urandom,
                     16'($urandom));
            else
                send(2'd3, 3'($urandom), 3'($urandom), 1'($urandom), $urandom, 16'($urandom));
        end
    endtask

    task automatic set_all(logic le, logic [15:0] cap, logic [1:0] ln, logic [15:0] seed);
        write_reg(CFG_LIMIT_ENABLE, {15'd0, le});
        write_reg(CFG_MAX_CELLS, cap);
        write_reg(CFG_LINES, {14'd0, ln});
        write_reg(CFG_LFSR_SEED, seed);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send(ACT_SCHEDULE, '0, '0, 0, '0, '0);
        send(ACT_LOAD_QUEUE, 3'd0, 3'd0, 1, 32'hFFFF_FFFF, '0);
        send(ACT_LOAD_QUEUE, 3'd7, 3'd7, 1, 32'h0, '0);
        send(ACT_LOAD_QUEUE, 3'd1, 3'd0, 1, 32'd5, '0);
        send(ACT_LOAD_QUEUE, 3'd1, 3'd3, 1, 32'd5, '0);
        send(ACT_LOAD_QUEUE, 3'd3, 3'd4, 0, 32'd0, '0);
        send(ACT_LOAD_QUEUE, 3'd4, 3'd2, 1, 32'd9, '0);
        send(ACT_LOAD_QUEUE, 3'd5, 3'd2, 1, 32'd9, '0);
        send(ACT_LOAD_QUEUE, 3'd6, 3'd2, 1, 32'd1, '0);
        send(ACT_LOAD_OCC, 3'd7, 3'd7, 1, '1, 16'hFFFF);
        send(ACT_LOAD_OCC, 3'd0, 3'd0, 0, '0, 16'd0);
        send(2'd3, 3'd7, 3'd7, 1, '1, '1);
        send(ACT_SCHEDULE, '0, '0, 0, '0, '0);
        random_items(25);
        settle();

        set_all(1, 16'hFFFF, 2'd2, 16'hACE1);
        @(negedge clk);
        send(ACT_SCHEDULE, '0, '0, 0, '0, '0);
        steady = 1;
        random_items(25);
        steady = 0;
        settle();

        // limit on with zero cap: nothing is eligible
        set_all(1, 16'd0, 2'd3, 16'd0);
        @(negedge clk);
        send(ACT_SCHEDULE, '0, '0, 0, '0, '0);
        random_items(15);
        settle();

        set_all(1, 16'd4, 2'd0, 16'hFFFF);
        @(negedge clk);
        random_items(20);
        settle();

        set_all(0, 16'd100, 2'd2, 16'h1234);
        @(negedge clk);
        hold_go = 1;
        for (int k = 0; k < 4; k++)
            send(ACT_SCHEDULE, '0, '0, 0, '0, '0);
        random_items(20);
        in_valid <= 0;
        wait (pending == 0);
        repeat (400) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

endmodule
